// ===== rtl/core/qte_pkg.sv =====
// Shared types, constants and the arctangent table of the quaternion to Euler converter.
`default_nettype none
package qte_pkg;

  // Width of the normalized CORDIC operands; the larger one lies in [2^29, 2^30).
  localparam int NORM_W    = 30;
  localparam int CORDIC_W  = 33;
  localparam int ACC_W     = 32;
  localparam int ANGLE_W   = 16;
  localparam int Q30_W     = 31;
  localparam int ISQ_W     = 62;
  localparam int ISQ_STEPS = 31;
  localparam int ATAN_LEN  = 24;

  localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(1) << 30;
  localparam logic [ISQ_W-1:0] ISQ_ONE = ISQ_W'(1) << 60;

  localparam logic signed [ACC_W-1:0]   ACC_MAX     = ACC_W'(9000 * 65536);
  localparam logic signed [ACC_W-1:0]   ACC_HALF    = ACC_W'(32768);
  localparam logic signed [ANGLE_W-1:0] QUARTER_ANG = ANGLE_W'(9000);
  localparam logic signed [ANGLE_W-1:0] HALF_ANG    = ANGLE_W'(18000);

  // Signs and degenerate cases of one atan2 evaluation.
  typedef struct packed {
    logic neg_s;
    logic neg_c;
    logic ay_zero;
    logic ax_zero;
  } ang_ctl_t;

  // atan(2^-i) in 1/65536 of a centidegree, rounded to nearest.
  function automatic logic [29:0] atan_entry(input int unsigned idx);
    logic [29:0] val;
    unique case (idx)
      0:  val = 30'd294912000;
      1:  val = 30'd174096719;
      2:  val = 30'd91987925;
      3:  val = 30'd46694507;
      4:  val = 30'd23437865;
      5:  val = 30'd11730358;
      6:  val = 30'd5866610;
      7:  val = 30'd2933484;
      8:  val = 30'd1466764;
      9:  val = 30'd733385;
      10: val = 30'd366693;
      11: val = 30'd183346;
      12: val = 30'd91673;
      13: val = 30'd45837;
      14: val = 30'd22918;
      15: val = 30'd11459;
      16: val = 30'd5730;
      17: val = 30'd2865;
      18: val = 30'd1432;
      19: val = 30'd716;
      20: val = 30'd358;
      21: val = 30'd179;
      22: val = 30'd90;
      23: val = 30'd45;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to ZYX Euler angle converter.
//
// A unit quaternion (w, x, y, z), each signed Q1.QUAT_FRAC_BITS, arrives as one
// transfer on the slave stream and leaves as roll, pitch and yaw in hundredths of
// a degree on the master stream, one result transfer per input transfer, in order.
// Roll and yaw span -18000..18000, pitch -9000..9000.
// The pipeline takes one transfer per cycle while the master side does not stall it.
// MAG_W, the magnitude width of the sine and cosine terms, is 34 for QUAT_FRAC_BITS
// up to 16. The 32-stage square root for the pitch cosine (one setup stage and one
// stage per result bit) and the CORDIC iterations, one per stage, make up most of
// the pipeline depth.
// All stages advance together: while a result waits on the master side with
// tready low, the whole pipeline holds and s_axis_tready is low; nothing is lost
// or repeated. Reset clears every valid bit, so the output is empty after reset.
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STEPS   = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z, 16 bits each
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata   // roll_centideg 16, pitch_centideg 15, yaw_centideg 16, pad
);

  localparam int PROD_W = (2 * QUAT_FRAC_BITS > 32) ? 2 * QUAT_FRAC_BITS : 32;
  localparam int TERM_W = PROD_W + 3;
  localparam int MAG_W  = TERM_W - 1;
  localparam int SB_W   = 4 * TERM_W;

  logic en;

  logic                     f_valid, f_pneg;
  logic signed [TERM_W-1:0] f_sr, f_cr, f_sy, f_cy;
  logic [Q30_W-1:0]         f_s30;

  logic                     q_valid;
  logic [Q30_W-1:0]         q_s30, q_c30;
  logic [SB_W-1:0]          q_sb;
  logic signed [TERM_W-1:0] q_sr, q_cr, q_sy, q_cy;
  logic                     q_pneg;

  logic [MAG_W-1:0] r_ay, r_ax, y_ay, y_ax;

  logic            rn_valid, pn_valid, yn_valid;
  logic [NORM_W-1:0] rn_ay, rn_ax, pn_ay, pn_ax, yn_ay, yn_ax;
  ang_ctl_t        rn_ctl, pn_ctl, yn_ctl;

  logic                      r_valid;
  logic signed [ANGLE_W-1:0] roll_ang, pitch_ang, yaw_ang;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  qte_front #(
    .FRAC_BITS (QUAT_FRAC_BITS),
    .TERM_W    (TERM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .quat_w_i    (s_axis_tdata[15:0]),
    .quat_x_i    (s_axis_tdata[31:16]),
    .quat_y_i    (s_axis_tdata[47:32]),
    .quat_z_i    (s_axis_tdata[63:48]),
    .valid_o     (f_valid),
    .sr_o        (f_sr),
    .cr_o        (f_cr),
    .sy_o        (f_sy),
    .cy_o        (f_cy),
    .s30_o       (f_s30),
    .pitch_neg_o (f_pneg)
  );

  // Roll and yaw terms ride along the square root pipeline as sideband.
  qte_isqrt #(
    .SB_W (SB_W + 1)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .s30_i   (f_s30),
    .sb_i    ({f_pneg, f_cy, f_sy, f_cr, f_sr}),
    .valid_o (q_valid),
    .s30_o   (q_s30),
    .c30_o   (q_c30),
    .sb_o    ({q_pneg, q_sb})
  );

  assign q_sr = q_sb[TERM_W-1:0];
  assign q_cr = q_sb[2*TERM_W-1:TERM_W];
  assign q_sy = q_sb[3*TERM_W-1:2*TERM_W];
  assign q_cy = q_sb[4*TERM_W-1:3*TERM_W];

  assign r_ay = q_sr[TERM_W-1] ? MAG_W'(-q_sr) : MAG_W'(q_sr);
  assign r_ax = q_cr[TERM_W-1] ? MAG_W'(-q_cr) : MAG_W'(q_cr);
  assign y_ay = q_sy[TERM_W-1] ? MAG_W'(-q_sy) : MAG_W'(q_sy);
  assign y_ax = q_cy[TERM_W-1] ? MAG_W'(-q_cy) : MAG_W'(q_cy);

  qte_norm #(.MAG_W(MAG_W)) u_norm_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_valid),
    .ay_i    (r_ay),
    .ax_i    (r_ax),
    .neg_s_i (q_sr[TERM_W-1]),
    .neg_c_i (q_cr[TERM_W-1]),
    .valid_o (rn_valid),
    .ay_o    (rn_ay),
    .ax_o    (rn_ax),
    .ctl_o   (rn_ctl)
  );

  qte_norm #(.MAG_W(MAG_W)) u_norm_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_valid),
    .ay_i    (MAG_W'(q_s30)),
    .ax_i    (MAG_W'(q_c30)),
    .neg_s_i (q_pneg),
    .neg_c_i (1'b0),
    .valid_o (pn_valid),
    .ay_o    (pn_ay),
    .ax_o    (pn_ax),
    .ctl_o   (pn_ctl)
  );

  qte_norm #(.MAG_W(MAG_W)) u_norm_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (q_valid),
    .ay_i    (y_ay),
    .ax_i    (y_ax),
    .neg_s_i (q_sy[TERM_W-1]),
    .neg_c_i (q_cy[TERM_W-1]),
    .valid_o (yn_valid),
    .ay_o    (yn_ay),
    .ax_o    (yn_ax),
    .ctl_o   (yn_ctl)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rn_valid),
    .ay_i    (rn_ay),
    .ax_i    (rn_ax),
    .ctl_i   (rn_ctl),
    .valid_o (r_valid),
    .angle_o (roll_ang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pn_valid),
    .ay_i    (pn_ay),
    .ax_i    (pn_ax),
    .ctl_i   (pn_ctl),
    .valid_o (),
    .angle_o (pitch_ang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (yn_valid),
    .ay_i    (yn_ay),
    .ax_i    (yn_ax),
    .ctl_i   (yn_ctl),
    .valid_o (),
    .angle_o (yaw_ang)
  );

  assign m_axis_tvalid = r_valid;
  assign m_axis_tdata  = {1'b0, yaw_ang, pitch_ang[14:0], roll_ang};

endmodule
`default_nettype wire

// ===== rtl/core/qte_front.sv =====
// Front end: quaternion products, the sine and cosine terms, and the pitch sine in Q30.
`default_nettype none
module qte_front import qte_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int TERM_W    = 35
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire                        valid_i,
  input  wire logic signed [15:0]    quat_w_i,
  input  wire logic signed [15:0]    quat_x_i,
  input  wire logic signed [15:0]    quat_y_i,
  input  wire logic signed [15:0]    quat_z_i,
  output logic                       valid_o,
  output logic signed [TERM_W-1:0]   sr_o,
  output logic signed [TERM_W-1:0]   cr_o,
  output logic signed [TERM_W-1:0]   sy_o,
  output logic signed [TERM_W-1:0]   cy_o,
  output logic [Q30_W-1:0]           s30_o,
  output logic                       pitch_neg_o
);

  localparam int F2      = 2 * FRAC_BITS;
  localparam int Q30_SHL = (F2 < 30) ? 30 - F2 : 0;
  localparam int Q30_SHR = (F2 > 30) ? F2 - 30 : 0;
  localparam int WIDE_W  = TERM_W + Q30_W;
  localparam logic [TERM_W-1:0] ONE_Q = TERM_W'(1) << F2;

  logic v1_q, v2_q, v3_q;

  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q;
  logic signed [31:0] p_zx_q, p_wz_q, p_xy_q, p_zz_q;

  logic signed [TERM_W-1:0] sr2_q, cr2_q, sp2_q, sy2_q, cy2_q;
  logic signed [TERM_W-1:0] sr2_d, cr2_d, sp2_d, sy2_d, cy2_d;

  logic signed [TERM_W-1:0] sr3_q, cr3_q, sy3_q, cy3_q;
  logic [Q30_W-1:0]         s30_q, s30_d;
  logic                     neg_q;

  logic [TERM_W-1:0] sp_mag, sp_clamp;
  logic [WIDE_W-1:0] q30_wide;

  always_comb begin
    sr2_d = (TERM_W'(p_wx_q) + TERM_W'(p_yz_q)) <<< 1;
    cr2_d = $signed(ONE_Q) - ((TERM_W'(p_xx_q) + TERM_W'(p_yy_q)) <<< 1);
    sp2_d = (TERM_W'(p_wy_q) - TERM_W'(p_zx_q)) <<< 1;
    sy2_d = (TERM_W'(p_wz_q) + TERM_W'(p_xy_q)) <<< 1;
    cy2_d = $signed(ONE_Q) - ((TERM_W'(p_yy_q) + TERM_W'(p_zz_q)) <<< 1);
  end

  // The pitch sine is clamped to one before it is rescaled to Q30.
  always_comb begin
    sp_mag   = sp2_q[TERM_W-1] ? $unsigned(-sp2_q) : $unsigned(sp2_q);
    sp_clamp = (sp_mag > ONE_Q) ? ONE_Q : sp_mag;
    q30_wide = ({{Q30_W{1'b0}}, sp_clamp} << Q30_SHL) >> Q30_SHR;
    s30_d    = (q30_wide > WIDE_W'(Q30_ONE)) ? Q30_ONE : q30_wide[Q30_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_wx_q <= 32'(quat_w_i) * 32'(quat_x_i);
      p_yz_q <= 32'(quat_y_i) * 32'(quat_z_i);
      p_xx_q <= 32'(quat_x_i) * 32'(quat_x_i);
      p_yy_q <= 32'(quat_y_i) * 32'(quat_y_i);
      p_wy_q <= 32'(quat_w_i) * 32'(quat_y_i);
      p_zx_q <= 32'(quat_z_i) * 32'(quat_x_i);
      p_wz_q <= 32'(quat_w_i) * 32'(quat_z_i);
      p_xy_q <= 32'(quat_x_i) * 32'(quat_y_i);
      p_zz_q <= 32'(quat_z_i) * 32'(quat_z_i);
      sr2_q  <= sr2_d;
      cr2_q  <= cr2_d;
      sp2_q  <= sp2_d;
      sy2_q  <= sy2_d;
      cy2_q  <= cy2_d;
      sr3_q  <= sr2_q;
      cr3_q  <= cr2_q;
      sy3_q  <= sy2_q;
      cy3_q  <= cy2_q;
      s30_q  <= s30_d;
      neg_q  <= sp2_q[TERM_W-1];
    end
  end

  assign valid_o     = v3_q;
  assign sr_o        = sr3_q;
  assign cr_o        = cr3_q;
  assign sy_o        = sy3_q;
  assign cy_o        = cy3_q;
  assign s30_o       = s30_q;
  assign pitch_neg_o = neg_q;

endmodule
`default_nettype wire

// ===== rtl/core/qte_isqrt.sv =====
// Pipelined square root giving the pitch cosine floor(sqrt(2^60 - s^2)), one result bit per stage.
`default_nettype none
module qte_isqrt import qte_pkg::*; #(
  parameter int SB_W = 8
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     valid_i,
  input  wire logic [Q30_W-1:0]   s30_i,
  input  wire logic [SB_W-1:0]    sb_i,
  output logic                    valid_o,
  output logic [Q30_W-1:0]        s30_o,
  output logic [Q30_W-1:0]        c30_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int NST = ISQ_STEPS + 1;

  logic             valid_q [NST];
  logic [ISQ_W-1:0] rem_q   [NST];
  logic [ISQ_W-1:0] res_q   [NST];
  logic [Q30_W-1:0] s30_q   [NST];
  logic [SB_W-1:0]  sb_q    [NST];

  logic [ISQ_W-1:0] sq;

  assign sq = ISQ_W'(s30_i) * ISQ_W'(s30_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ISQ_ONE - sq;
      res_q[0] <= '0;
      s30_q[0] <= s30_i;
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (60 - 2 * j);
    logic [ISQ_W-1:0] trial, rem_d, res_d;

    always_comb begin
      trial = res_q[j] + BIT;
      if (rem_q[j] >= trial) begin
        rem_d = rem_q[j] - trial;
        res_d = (res_q[j] >> 1) + BIT;
      end else begin
        rem_d = rem_q[j];
        res_d = res_q[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[j+1] <= valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= rem_d;
        res_q[j+1] <= res_d;
        s30_q[j+1] <= s30_q[j];
        sb_q[j+1]  <= sb_q[j];
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign s30_o   = s30_q[NST-1];
  assign c30_o   = res_q[NST-1][Q30_W-1:0];
  assign sb_o    = sb_q[NST-1];

endmodule
`default_nettype wire

// ===== rtl/core/qte_norm.sv =====
// Normalizing shifter: scales a vector pair so the larger magnitude lands in [2^29, 2^30).
`default_nettype none
module qte_norm import qte_pkg::*; #(
  parameter int MAG_W = 34
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     valid_i,
  input  wire logic [MAG_W-1:0]   ay_i,
  input  wire logic [MAG_W-1:0]   ax_i,
  input  wire logic               neg_s_i,
  input  wire logic               neg_c_i,
  output logic                    valid_o,
  output logic [NORM_W-1:0]       ay_o,
  output logic [NORM_W-1:0]       ax_o,
  output ang_ctl_t                ctl_o
);

  localparam int NS = $clog2(MAG_W);

  logic             valid_q [NS];
  logic [MAG_W-1:0] ay_q    [NS];
  logic [MAG_W-1:0] ax_q    [NS];
  ang_ctl_t         ctl_q   [NS];

  ang_ctl_t ctl_in;

  always_comb begin
    ctl_in.neg_s   = neg_s_i;
    ctl_in.neg_c   = neg_c_i;
    ctl_in.ay_zero = (ay_i == '0);
    ctl_in.ax_zero = (ax_i == '0);
  end

  // Shifting left until the top bit of the larger magnitude is set, then keeping the
  // upper bits, equals a truncating right shift or an exact left shift into range.
  for (genvar k = 0; k < NS; k++) begin : g_shift
    localparam int SH = 1 << (NS - 1 - k);
    logic             v_in;
    logic [MAG_W-1:0] ay_in, ax_in, orv;
    ang_ctl_t         c_in;
    logic             hit;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign ay_in = ay_i;
      assign ax_in = ax_i;
      assign c_in  = ctl_in;
    end else begin : g_next
      assign v_in  = valid_q[k-1];
      assign ay_in = ay_q[k-1];
      assign ax_in = ax_q[k-1];
      assign c_in  = ctl_q[k-1];
    end

    assign orv = ay_in | ax_in;
    assign hit = (orv[MAG_W-1 -: SH] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ay_q[k]  <= hit ? (ay_in << SH) : ay_in;
        ax_q[k]  <= hit ? (ax_in << SH) : ax_in;
        ctl_q[k] <= c_in;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign ay_o    = ay_q[NS-1][MAG_W-1 -: NORM_W];
  assign ax_o    = ax_q[NS-1][MAG_W-1 -: NORM_W];
  assign ctl_o   = ctl_q[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/qte_cordic.sv =====
// Unrolled vectoring CORDIC with the rounding, special cases and quadrant fold of atan2.
`default_nettype none
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        en_i,
  input  wire                        valid_i,
  input  wire logic [NORM_W-1:0]     ay_i,
  input  wire logic [NORM_W-1:0]     ax_i,
  input  wire ang_ctl_t              ctl_i,
  output logic                       valid_o,
  output logic signed [ANGLE_W-1:0]  angle_o
);

  logic                       valid_q [STEPS];
  logic signed [CORDIC_W-1:0] x_q     [STEPS];
  logic signed [CORDIC_W-1:0] y_q     [STEPS];
  logic signed [ACC_W-1:0]    z_q     [STEPS];
  ang_ctl_t                   ctl_q   [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ACC_W-1:0] TAB = $signed(ACC_W'(atan_entry(i)));
    logic                       v_in;
    logic signed [CORDIC_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [ACC_W-1:0]    z_in, z_d;
    ang_ctl_t                   c_in;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = $signed(CORDIC_W'(ax_i));
      assign y_in = $signed(CORDIC_W'(ay_i));
      assign z_in = '0;
      assign c_in = ctl_i;
    end else begin : g_next
      assign v_in = valid_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign c_in = ctl_q[i-1];
    end

    always_comb begin
      if (!y_in[CORDIC_W-1]) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + TAB;
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - TAB;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]   <= x_d;
        y_q[i]   <= y_d;
        z_q[i]   <= z_d;
        ctl_q[i] <= c_in;
      end
    end
  end

  logic signed [ACC_W-1:0]   z_fin, z_clamp, z_round;
  logic signed [ANGLE_W-1:0] quad, folded, angle_d, angle_q;
  logic                      valid_out_q;
  ang_ctl_t                  c_fin;

  always_comb begin
    z_fin = z_q[STEPS-1];
    c_fin = ctl_q[STEPS-1];
    if (z_fin[ACC_W-1]) begin
      z_clamp = '0;
    end else if (z_fin > ACC_MAX) begin
      z_clamp = ACC_MAX;
    end else begin
      z_clamp = z_fin;
    end
    z_round = (z_clamp + ACC_HALF) >>> 16;
    // A zero sine term wins over a zero cosine term.
    if (c_fin.ay_zero) begin
      quad = '0;
    end else if (c_fin.ax_zero) begin
      quad = QUARTER_ANG;
    end else begin
      quad = z_round[ANGLE_W-1:0];
    end
    folded  = c_fin.neg_c ? (HALF_ANG - quad) : quad;
    angle_d = c_fin.neg_s ? -folded : folded;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else if (en_i) begin
      valid_out_q <= valid_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_out_q;
  assign angle_o = angle_q;

endmodule
`default_nettype wire
